### rtl/core/relative_vector_word_decoder_assert.svh
// Assertion macros shared by the vector word decoder RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef RELATIVE_VECTOR_WORD_DECODER_ASSERT_SVH
`define RELATIVE_VECTOR_WORD_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Antecedent in this cycle implies consequent in the same cycle.
`define RVWD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rvwd assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define RVWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rvwd assertion failed");

// Condition must never be seen.
`define RVWD_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rvwd assertion failed");

`else

`define RVWD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RVWD_ASSERT_NEXT(label, clk, rst, ante, cons)
`define RVWD_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

### rtl/core/rvwd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the relative vector word decoder.
// No dependencies; imported by every module of the block.
package rvwd_pkg;

   // Start coordinates at or above this limit (or zero) clamp to zero
   localparam int unsigned START_LIMIT = 5000;

   // Decode queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_SHIFT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_SHIFT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZOOM_FACTOR = 2'd2;

   // Word format fields
   localparam int unsigned DELTA_W = 13;

   typedef enum logic {
      ACTION_START = 1'b0,
      ACTION_WORD  = 1'b1
   } action_type;

   typedef struct packed {
      logic        action;
      logic [15:0] data_word;
      logic [15:0] start_x;
      logic [15:0] start_y;
      logic        end_of_record;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               pen_down;
      logic               last_point;
   } rsp_type;

   typedef struct packed {
      logic [3:0] x_shift;
      logic [3:0] y_shift;
      logic [7:0] zoom_factor;
   } cfg_type;

   // One classified item handed from front to back
   typedef struct packed {
      logic                      is_start;
      logic                      pen_down;
      logic                      last_point;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [15:0]               start_x;
      logic [15:0]               start_y;
   } op_type;

endpackage

### rtl/core/rvwd_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of decoded operations between front and back.
// Depends on rvwd_pkg and the assertion macro header.
`include "relative_vector_word_decoder_assert.svh"

module rvwd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rvwd_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            empty,
   output rvwd_pkg::op_type head_op
);
   import rvwd_pkg::*;

   op_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]  count_ff, count_in;

   assign full    = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = entries_ff[rd_ptr_ff];

   // Advance pointers with explicit wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   `RVWD_ASSERT_NEVER(a_queue_overfill, clock, reset, count_ff > QUEUE_CW'(QUEUE_DEPTH))
   `RVWD_ASSERT_IMPLY(a_queue_no_pop_empty, clock, reset, pop, !empty)

endmodule

### rtl/core/rvwd_front.sv
`timescale 1ns / 1ps
// Front end: accepts request beats, classifies words and pairs long-form halves.
// Depends on rvwd_pkg and the assertion macro header.
`include "relative_vector_word_decoder_assert.svh"

module rvwd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rvwd_pkg::req_type req_payload,
   input  logic             queue_full,
   output logic             push,
   output rvwd_pkg::op_type push_op
);
   import rvwd_pkg::*;

   logic        pend_valid_ff, pend_valid_in;
   logic [15:0] pend_word_ff, pend_word_in;

   logic        accept;
   logic        is_start;
   logic        is_second;
   logic        is_short;
   logic        is_first;
   logic [15:0] word;

   // Zero a start coordinate outside 1..START_LIMIT-1
   function automatic logic [15:0] clamp_start(input logic [15:0] v);
      logic in_range;
      in_range = (v != '0) && (v < 16'(START_LIMIT));
      return in_range ? v : '0;
   endfunction

   assign word      = req_payload.data_word;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Classify the beat; a word after a pending half always completes it
   assign is_start  = (req_payload.action == ACTION_START);
   assign is_second = !is_start && pend_valid_ff;
   assign is_short  = !is_start && !pend_valid_ff && word[15];
   assign is_first  = !is_start && !pend_valid_ff && !word[15];

   assign push = accept && !is_first;

   // Build the operation for the back end
   always_comb begin
      push_op            = '0;
      push_op.is_start   = is_start;
      push_op.last_point = req_payload.end_of_record;
      push_op.start_x    = clamp_start(req_payload.start_x);
      push_op.start_y    = clamp_start(req_payload.start_y);
      if (is_second) begin
         push_op.dx       = pend_word_ff[DELTA_W-1:0];
         push_op.dy       = word[DELTA_W-1:0];
         push_op.pen_down = !word[13];
      end else begin
         push_op.dx       = {{(DELTA_W-7){word[14]}}, word[14:8]};
         push_op.dy       = {{(DELTA_W-7){word[6]}}, word[6:0]};
         push_op.pen_down = !is_start && !word[7];
      end
   end

   // Hold a first half until its partner; drop it at record end or on a start
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      if (accept) begin
         if (is_first && !req_payload.end_of_record) begin
            pend_valid_in = 1'b1;
            pend_word_in  = word;
         end else begin
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_word_ff <= pend_word_in;
   end

   `RVWD_ASSERT_NEXT(a_front_start_clears, clock, reset, accept && is_start, !pend_valid_ff)
   `RVWD_ASSERT_IMPLY(a_front_second_pushes, clock, reset, accept && pend_valid_ff, push)

endmodule

### rtl/core/rvwd_back.sv
`timescale 1ns / 1ps
// Back end: scales deltas, accumulates the position and holds the response beat.
// Depends on rvwd_pkg and the assertion macro header.
`include "relative_vector_word_decoder_assert.svh"

module rvwd_back (
   input  logic             clock,
   input  logic             reset,
   input  rvwd_pkg::cfg_type cfg,
   input  logic             queue_empty,
   input  rvwd_pkg::op_type head_op,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rvwd_pkg::rsp_type rsp_payload
);
   import rvwd_pkg::*;

   // Stage 1: scaled deltas
   logic        s1_valid_ff, s1_valid_in;
   op_type      s1_op_ff, s1_op_in;
   logic [31:0] s1_dx_ff, s1_dx_in;
   logic [31:0] s1_dy_ff, s1_dy_in;

   // Stage 2: position and response register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] cur_x_ff, cur_x_in;
   logic [31:0] cur_y_ff, cur_y_in;

   logic        adv;
   logic [31:0] dx_shl;
   logic [31:0] dy_shl;
   logic [31:0] dx_mul;
   logic [31:0] dy_mul;

   // Move the whole pipe unless the response beat is stalled
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !queue_empty;

   // Shift and zoom each delta; only the low 32 bits matter
   always_comb begin
      dx_shl   = {{(32-DELTA_W){head_op.dx[DELTA_W-1]}}, head_op.dx} << cfg.x_shift;
      dy_shl   = {{(32-DELTA_W){head_op.dy[DELTA_W-1]}}, head_op.dy} << cfg.y_shift;
      dx_mul   = dx_shl * 32'(cfg.zoom_factor);
      dy_mul   = dy_shl * 32'(cfg.zoom_factor);
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_dx_in    = s1_dx_ff;
      s1_dy_in    = s1_dy_ff;
      if (adv) begin
         s1_valid_in = !queue_empty;
         s1_op_in    = head_op;
         s1_dx_in    = dx_mul;
         s1_dy_in    = dy_mul;
      end
   end

   // Load or advance the position and capture the response
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      if (adv) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            if (s1_op_ff.is_start) begin
               cur_x_in = {16'd0, s1_op_ff.start_x};
               cur_y_in = {16'd0, s1_op_ff.start_y};
            end else begin
               cur_x_in = cur_x_ff + s1_dx_ff;
               cur_y_in = cur_y_ff + s1_dy_ff;
            end
            rsp_in.point_x    = cur_x_in;
            rsp_in.point_y    = cur_y_in;
            rsp_in.pen_down   = s1_op_ff.pen_down;
            rsp_in.last_point = s1_op_ff.last_point;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff <= s1_op_in;
      s1_dx_ff <= s1_dx_in;
      s1_dy_ff <= s1_dy_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `RVWD_ASSERT_NEXT(a_back_hold_stage1, clock, reset,
      s1_valid_ff && rsp_valid_ff && rsp_stall, s1_valid_ff && $stable(s1_dx_ff))

endmodule

### rtl/core/relative_vector_word_decoder.sv
`timescale 1ns / 1ps
// Relative vector word decoder: turns packed relative vector words into points.
// Channels: req (valid/stall) takes one beat per start item or 16-bit word;
// rsp (valid/stall) gives one beat per emitted point; csr (valid/ready) writes
// x_shift, y_shift and zoom_factor and is always ready.
// A start beat emits the clamped start point as a move. A short-form word emits
// one point; a long form emits one point on its second word, nothing on its
// first. Coordinates wrap in 32 bits.
// An item moves from the queue to stage 1, then to the response register.
// Throughput: one beat per cycle while req_stall is low, set by the
// combinational front classifier and the two-stage scale/accumulate back end;
// the four-entry queue between them absorbs short response stalls.
// While rsp is stalled the response beat holds, the back end freezes and the
// queue fills; once it is full req_stall rises.
// Reset (synchronous) clears the position, any pending half-word, the queue
// and the registers (shifts 0, zoom 1). Write registers only while idle.
// Depends on rvwd_pkg, rvwd_front, rvwd_queue and rvwd_back.

module relative_vector_word_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rvwd_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rvwd_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rvwd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [7:0]                            csr_wdata
);
   import rvwd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    queue_full;
   logic    queue_empty;
   logic    push;
   logic    pop;
   op_type  push_op;
   op_type  head_op;

   assign csr_ready = 1'b1;

   // Register writes; unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_X_SHIFT:     cfg_in.x_shift     = csr_wdata[3:0];
            CSR_Y_SHIFT:     cfg_in.y_shift     = csr_wdata[3:0];
            CSR_ZOOM_FACTOR: cfg_in.zoom_factor = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_shift     <= 4'd0;
         cfg_ff.y_shift     <= 4'd0;
         cfg_ff.zoom_factor <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rvwd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_op     (push_op)
   );

   rvwd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (pop),
      .empty   (queue_empty),
      .head_op (head_op)
   );

   rvwd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head_op     (head_op),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### tb/vector_point_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the relative vector word decoder: predicts every point from the
// req and csr beats it sees and compares rsp beats against them in order.
// Depends on rvwd_pkg only.
module vector_point_checker
   import rvwd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output int                     points_waiting,
   output int                     fail_count
);

   localparam int REPORT_LIMIT = 10;

   // Register copies
   logic [3:0]  shift_x;
   logic [3:0]  shift_y;
   logic [7:0]  zoom;

   // Decoder state: pen position and the held first half of a long form
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [15:0] half_word;
   logic        half_held;

   rsp_type     expected_points[$];
   int          failures = 0;

   function automatic logic [31:0] clamp_start(input logic [15:0] coord);
      return (coord != 16'd0 && coord < START_LIMIT) ? {16'd0, coord} : 32'd0;
   endfunction

   // Shift, scale and add; everything wraps in 32 bits
   function automatic void advance_position(input logic [31:0] dx, input logic [31:0] dy);
      pos_x = pos_x + (dx << shift_x) * {24'd0, zoom};
      pos_y = pos_y + (dy << shift_y) * {24'd0, zoom};
   endfunction

   // Returns 1 when the beat produces a point
   function automatic bit decode_point(input req_type item, output rsp_type point);
      logic [15:0] word;
      logic        pen;
      word = item.data_word;
      point = '0;
      if (item.action == ACTION_START) begin
         pos_x = clamp_start(item.start_x);
         pos_y = clamp_start(item.start_y);
         half_held = 1'b0;
         half_word = '0;
         pen = 1'b0;
      end else if (half_held) begin
         // second half of a long form, whatever its top bit says
         advance_position({{19{half_word[12]}}, half_word[12:0]},
                          {{19{word[12]}}, word[12:0]});
         half_held = 1'b0;
         half_word = '0;
         pen = !word[13];
      end else if (word[15]) begin
         advance_position({{25{word[14]}}, word[14:8]}, {{25{word[6]}}, word[6:0]});
         pen = !word[7];
      end else begin
         // first half: hold it, or drop it when the record ends here
         half_held = !item.end_of_record;
         half_word = item.end_of_record ? 16'd0 : word;
         return 1'b0;
      end
      point.point_x = pos_x;
      point.point_y = pos_y;
      point.pen_down = pen;
      point.last_point = item.end_of_record;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type point;
      if (reset) begin
         shift_x = '0;
         shift_y = '0;
         zoom = 8'd1;
         pos_x = '0;
         pos_y = '0;
         half_word = '0;
         half_held = 1'b0;
         expected_points.delete();
      end else begin
         // compare the response beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: unexpected point x=%0d y=%0d pen=%0b last=%0b", $realtime,
                           rsp_payload.point_x, rsp_payload.point_y,
                           rsp_payload.pen_down, rsp_payload.last_point);
            end else begin
               want = expected_points.pop_front();
               if (rsp_payload.point_x !== want.point_x ||
                   rsp_payload.point_y !== want.point_y ||
                   rsp_payload.pen_down !== want.pen_down ||
                   rsp_payload.last_point !== want.last_point) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("%0t: point mismatch exp x=%0d y=%0d pen=%0b last=%0b",
                              $realtime, want.point_x, want.point_y, want.pen_down,
                              want.last_point, "  got x=%0d y=%0d pen=%0b last=%0b",
                              rsp_payload.point_x, rsp_payload.point_y,
                              rsp_payload.pen_down, rsp_payload.last_point);
               end
            end
         end

         // track register writes; the unused index is dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_X_SHIFT:     shift_x = csr_wdata[3:0];
               CSR_Y_SHIFT:     shift_y = csr_wdata[3:0];
               CSR_ZOOM_FACTOR: zoom = csr_wdata;
               default: ;
            endcase
         end

         // predict from the accepted request beat
         if (req_valid && !req_stall) begin
            if (decode_point(req_payload, point))
               expected_points.push_back(point);
         end
      end
      points_waiting <= expected_points.size();
      fail_count <= failures;
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the relative vector word decoder bench: clock, reset, stimulus and verdict.
// Depends on rvwd_pkg, the decoder RTL and vector_point_checker.
module testbench;
   import rvwd_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 142;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_PERCENT  = 34;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_wdata = '0;

   int points_waiting;
   int fail_count;
   int cycle_count = 0;
   int items_sent = 0;
   bit steady = 1'b0;

   relative_vector_word_decoder uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   vector_point_checker point_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .points_waiting(points_waiting), .fail_count(fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic bit idle_roll();
      return !steady && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_stall <= idle_roll();
   end

   // Unused fields still get random content
   function automatic req_type make_start(input logic [15:0] x, input logic [15:0] y,
                                          input logic eor);
      return {ACTION_START, 16'($urandom), x, y, eor};
   endfunction

   function automatic req_type make_word(input logic [15:0] word, input logic eor);
      return {ACTION_WORD, word, 16'($urandom), 16'($urandom), eor};
   endfunction

   // Present one beat, maybe after an idle gap, and hold it until taken
   task automatic send_beat(input req_type item);
      if (idle_roll()) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (idle_roll());
      end
      req_payload <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [7:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_settings(input logic [7:0] xs, input logic [7:0] ys,
                                 input logic [7:0] zoom);
      write_reg(CSR_X_SHIFT, xs);
      write_reg(CSR_Y_SHIFT, ys);
      write_reg(CSR_ZOOM_FACTOR, zoom);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every predicted point, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (points_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One well-formed record, sometimes empty or cut off on a first half
   task automatic send_record();
      int          vectors;
      logic [15:0] sx;
      logic [15:0] sy;
      bit          broken;
      bit          closing;
      case ($urandom_range(3))
         0, 1: begin
            sx = 16'($urandom_range(1, START_LIMIT - 1));
            sy = 16'($urandom_range(1, START_LIMIT - 1));
         end
         2: begin
            sx = $urandom_range(1) ? 16'd0 : 16'($urandom_range(START_LIMIT, 65535));
            sy = $urandom_range(1) ? 16'd0 : 16'($urandom_range(START_LIMIT, 65535));
         end
         default: begin
            sx = 16'($urandom);
            sy = 16'($urandom);
         end
      endcase
      if ($urandom_range(19) == 0) begin
         send_beat(make_start(sx, sy, 1'b1));
         return;
      end
      send_beat(make_start(sx, sy, 1'b0));
      vectors = $urandom_range(1, 10);
      broken = ($urandom_range(9) == 0);
      for (int i = 0; i < vectors; i++) begin
         closing = !broken && (i == vectors - 1);
         if ($urandom_range(99) < 55) begin
            send_beat(make_word({1'b1, 15'($urandom)}, closing));
         end else begin
            send_beat(make_word({1'b0, 15'($urandom)}, 1'b0));
            send_beat(make_word(16'($urandom), closing));
         end
      end
      if (broken)
         send_beat(make_word({1'b0, 15'($urandom)}, 1'b1));
   endtask

   // Mostly records, some fully random beats
   task automatic run_random(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(99) < 15)
            send_beat({1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom)});
         else
            send_record();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at reset settings
      send_beat(make_word(16'hBF40, 1'b0));              // words before any start
      send_beat(make_start(16'd0, 16'd0, 1'b0));
      send_beat(make_start(16'd1, 16'd4999, 1'b0));
      send_beat(make_start(16'd5000, 16'hFFFF, 1'b1));   // empty record
      send_beat(make_start(16'd4999, 16'd1, 1'b0));
      send_beat(make_word(16'hC0BF, 1'b0));              // short, dx min, dy max, blank
      send_beat(make_word(16'h8080, 1'b0));              // short zero move
      send_beat(make_word(16'hFFFF, 1'b0));
      send_beat(make_word(16'h0FFF, 1'b0));              // long, dx max
      send_beat(make_word(16'h1000, 1'b0));              // dy min, drawn
      send_beat(make_word(16'h7000, 1'b0));              // ignored bits set in first half
      send_beat(make_word(16'hFFFF, 1'b0));              // top bit set, still a second half
      send_beat(make_word(16'h1FFF, 1'b0));
      send_beat(make_word(16'h2FFF, 1'b0));              // blank long form
      send_beat(make_word(16'h0123, 1'b1));              // record ends on a first half
      send_beat(make_word(16'h8101, 1'b1));
      send_beat(make_start(16'd10, 16'd20, 1'b0));
      send_beat(make_word(16'h0555, 1'b0));              // half dropped by the next start
      send_beat(make_start(16'd30, 16'd40, 1'b0));
      send_beat(make_word(16'h8282, 1'b1));
      send_beat(make_start(16'd100, 16'd200, 1'b0));
      send_beat(make_word(16'h0001, 1'b0));
      send_beat(make_word(16'h3FFF, 1'b1));              // record ends on a second half
      drain();

      // Random phases across register settings
      write_reg(CSR_UNUSED, 8'($urandom));
      write_settings(8'd15, 8'd15, 8'd255);
      run_random(PHASE_ITEMS);
      drain();

      write_settings(8'd0, 8'd0, 8'd0);
      run_random(PHASE_ITEMS);
      drain();

      // no idling on either side through this phase
      steady = 1'b1;
      write_settings(8'd3, 8'd7, 8'd2);
      run_random(PHASE_ITEMS);
      drain();
      steady = 1'b0;

      // upper bits of the shift writes must be masked
      write_settings(8'hF5, 8'hFA, 8'd17);
      run_random(PHASE_ITEMS);
      drain();

      write_settings(8'd0, 8'd0, 8'd1);
      run_random(PHASE_ITEMS);
      drain();

      write_settings(8'($urandom), 8'($urandom), 8'($urandom));
      run_random(PHASE_ITEMS);
      drain();

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
